// ----- sv/tpbf_pkg.sv -----
// Shared types and constants of the text page break finder.
// Used by the front, queue, back, top level and checker; depends on nothing.
package tpbf_pkg;

    // Byte classes as the front sees them, without any layout context.
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_CR,
        CLS_LF,
        CLS_LEAD,
        CLS_ZW,
        CLS_HALF
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic hi_trail;
        logic eot;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [6:0] glyph_size;
        logic [9:0] width_limit;
        logic [9:0] bottom_limit;
        logic [9:0] top_y;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_GLYPH_SIZE,
        REG_WIDTH_LIMIT,
        REG_BOTTOM_LIMIT,
        REG_TOP_Y
    } reg_idx_t;

    localparam logic [1:0] REASON_FULL = 2'd0;
    localparam logic [1:0] REASON_END  = 2'd1;
    localparam logic [1:0] REASON_WIDE = 2'd2;

    localparam logic [6:0] GLYPH_SIZE_RESET   = 7'd16;
    localparam logic [9:0] WIDTH_LIMIT_RESET  = 10'd385;
    localparam logic [9:0] BOTTOM_LIMIT_RESET = 10'd290;
    localparam logic [9:0] TOP_Y_RESET        = 10'd44;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] LEAD_LOW   = 8'h81;
    localparam logic [7:0] LEAD_HIGH  = 8'hFE;
    localparam logic [7:0] TRAIL_FULL = 8'h40;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] LINE_GAP   = 8'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

endpackage

// ----- sv/tpbf_front.sv -----
// Front part of the page break finder: accepts text bytes and classifies them.
// Depends on tpbf_pkg; pushes classified items into tpbf_queue.
module tpbf_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  tpbf_pkg::q_status_t q_stat,
    output logic              q_push,
    output tpbf_pkg::item_t   q_item
);
    import tpbf_pkg::*;

    cls_t cls;

    always_comb
    begin
        if (text_byte == BYTE_NUL)
        begin
            cls = CLS_ZERO;
        end
        else if (text_byte == BYTE_CR)
        begin
            cls = CLS_CR;
        end
        else if (text_byte == BYTE_LF)
        begin
            cls = CLS_LF;
        end
        else if (text_byte inside {[LEAD_LOW:LEAD_HIGH]})
        begin
            cls = CLS_LEAD;
        end
        else if (text_byte >= HIGH_BIT)
        begin
            cls = CLS_ZW;
        end
        else
        begin
            cls = CLS_HALF;
        end
    end

    assign in_stall        = q_stat.full;
    assign q_push          = in_valid && !q_stat.full;
    assign q_item.cls      = cls;
    // Only meaningful when the byte turns out to be a trail byte.
    assign q_item.hi_trail = (text_byte >= TRAIL_FULL);
    assign q_item.eot      = end_of_text;

endmodule

// ----- sv/tpbf_queue.sv -----
// Short queue of classified items between the front and back parts.
// Depends on tpbf_pkg for the item type and the queue depth.
module tpbf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tpbf_pkg::item_t     push_item,
    input  logic                pop,
    output tpbf_pkg::item_t     head_item,
    output tpbf_pkg::q_status_t stat
);
    import tpbf_pkg::*;

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/tpbf_back.sv -----
// Back part of the page break finder: line layout state and the result register.
// Depends on tpbf_pkg; takes one item from tpbf_queue per cycle unless stalled.
module tpbf_back #(
    parameter int LINE_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tpbf_pkg::cfg_t      cfg,
    input  tpbf_pkg::q_status_t q_stat,
    input  tpbf_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         page_bytes,
    output logic [1:0]          end_reason
);
    import tpbf_pkg::*;

    localparam int LBW = $clog2(LINE_BYTES);
    localparam logic [LBW:0] LINE_LIMIT = (LBW+1)'(LINE_BYTES - 2);

    logic [10:0]    cursor_reg,    cursor_next;
    logic [10:0]    width_reg,     width_next;
    logic [LBW-1:0] lbytes_reg,    lbytes_next;
    logic [15:0]    consumed_reg,  consumed_next;
    logic [15:0]    committed_reg, committed_next;
    logic           lead_reg,      lead_next;
    logic           cr_reg,        cr_next;
    logic           done_reg,      done_next;
    logic           open_reg,      open_next;
    logic           out_valid_reg;
    logic [15:0]    page_bytes_reg;
    logic [1:0]     end_reason_reg;
    logic           res_valid;
    logic [15:0]    res_bytes;
    logic [1:0]     res_reason;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] n);
        logic [16:0] s;
        s = {1'b0, a} + 17'(n);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    assign q_pop = !q_stat.empty && (!out_valid_reg || !out_stall);

    // One full layout step per item: pending CR or lead byte, the byte itself,
    // then the end-of-text handling, all on a working copy of the state.
    always_comb
    begin
        logic [11:0]    cy;
        logic [10:0]    lw;
        logic [LBW-1:0] lb;
        logic [15:0]    cons;
        logic [15:0]    comm;
        logic           lp;
        logic           crp;
        logic           pd;
        logic [7:0]     lh;
        logic [6:0]     half;
        logic           fresh;
        logic           do_place;
        logic           do_end;
        logic           placed;
        logic [1:0]     plen;
        logic [6:0]     pw;

        cy        = open_reg ? {1'b0, cursor_reg} : {2'b0, cfg.top_y};
        lw        = width_reg;
        lb        = lbytes_reg;
        cons      = consumed_reg;
        comm      = committed_reg;
        lp        = lead_reg;
        crp       = cr_reg;
        pd        = done_reg;
        lh        = {1'b0, cfg.glyph_size} + LINE_GAP;
        half      = cfg.glyph_size >> 1;
        fresh     = 1'b0;
        do_place  = 1'b0;
        do_end    = 1'b0;
        placed    = 1'b0;
        plen      = 2'd1;
        pw        = '0;
        res_valid = 1'b0;
        res_bytes = committed_reg;
        res_reason = REASON_FULL;

        if (!pd)
        begin
            if (crp)
            begin
                crp = 1'b0;
                if (q_item.cls == CLS_LF)
                begin
                    cons = sat_add(cons, 2'd2);
                    cy   = cy + 12'(lh);
                    comm = cons;
                end
                else
                begin
                    cons  = sat_add(cons, 2'd1);
                    cy    = cy + 12'(lh);
                    comm  = cons;
                    fresh = 1'b1;
                end
            end
            else if (lp)
            begin
                lp       = 1'b0;
                do_place = 1'b1;
                if (q_item.cls == CLS_ZERO)
                begin
                    // Lead byte followed by a terminator stands alone at zero width.
                    plen   = 2'd1;
                    pw     = '0;
                    do_end = 1'b1;
                end
                else
                begin
                    plen = 2'd2;
                    pw   = q_item.hi_trail ? cfg.glyph_size : half;
                end
            end
            else
            begin
                fresh = 1'b1;
            end
        end

        if (fresh)
        begin
            case (q_item.cls)
                CLS_ZERO:
                begin
                    do_end = 1'b1;
                end
                CLS_CR, CLS_LF:
                begin
                    if (lb != '0)
                    begin
                        cy   = cy + 12'(lh);
                        lw   = '0;
                        lb   = '0;
                        comm = cons;
                    end
                    if ((cy + 12'(lh)) > {2'b0, cfg.bottom_limit})
                    begin
                        pd         = 1'b1;
                        res_valid  = 1'b1;
                        res_bytes  = comm;
                        res_reason = REASON_FULL;
                    end
                    else if (q_item.cls == CLS_LF)
                    begin
                        cons = sat_add(cons, 2'd1);
                        cy   = cy + 12'(lh);
                        comm = cons;
                    end
                    else
                    begin
                        crp = 1'b1;
                    end
                end
                CLS_LEAD:
                begin
                    if (lb == '0 && (cy + 12'(lh)) > {2'b0, cfg.bottom_limit})
                    begin
                        pd         = 1'b1;
                        res_valid  = 1'b1;
                        res_bytes  = comm;
                        res_reason = REASON_FULL;
                    end
                    else
                    begin
                        lp = 1'b1;
                    end
                end
                CLS_ZW:
                begin
                    do_place = 1'b1;
                    plen     = 2'd1;
                    pw       = '0;
                end
                default:
                begin
                    do_place = 1'b1;
                    plen     = 2'd1;
                    pw       = half;
                end
            endcase
        end

        if (q_item.eot)
        begin
            if (!pd && crp)
            begin
                // A lone CR at the end still counts as one newline byte.
                crp  = 1'b0;
                cons = sat_add(cons, 2'd1);
                cy   = cy + 12'(lh);
                comm = cons;
            end
            if (!pd && lp)
            begin
                lp       = 1'b0;
                do_place = 1'b1;
                plen     = 2'd1;
                pw       = '0;
            end
        end

        if (do_place && !pd)
        begin
            if (lb != '0)
            begin
                if ((({1'b0, lb} + (LBW+1)'(plen)) < LINE_LIMIT) &&
                    (({1'b0, lw} + 12'(pw)) <= {2'b0, cfg.width_limit}))
                begin
                    lb     = lb + LBW'(plen);
                    lw     = lw + 11'(pw);
                    cons   = sat_add(cons, plen);
                    placed = 1'b1;
                end
                else
                begin
                    cy   = cy + 12'(lh);
                    lw   = '0;
                    lb   = '0;
                    comm = cons;
                end
            end
            if (!placed)
            begin
                if ((cy + 12'(lh)) > {2'b0, cfg.bottom_limit})
                begin
                    pd         = 1'b1;
                    res_valid  = 1'b1;
                    res_bytes  = comm;
                    res_reason = REASON_FULL;
                end
                else if (((LBW+1)'(plen) >= LINE_LIMIT) || ({3'b0, pw} > cfg.width_limit))
                begin
                    pd         = 1'b1;
                    res_valid  = 1'b1;
                    res_bytes  = comm;
                    res_reason = REASON_WIDE;
                end
                else
                begin
                    lb   = LBW'(plen);
                    lw   = 11'(pw);
                    cons = sat_add(cons, plen);
                end
            end
        end

        if ((do_end || q_item.eot) && !pd)
        begin
            if (lb != '0)
            begin
                cy   = cy + 12'(lh);
                lw   = '0;
                lb   = '0;
                comm = cons;
            end
            pd         = 1'b1;
            res_valid  = 1'b1;
            res_bytes  = comm;
            res_reason = REASON_END;
        end

        cursor_next = cy[10:0];
        if (q_item.eot)
        begin
            width_next     = '0;
            lbytes_next    = '0;
            consumed_next  = '0;
            committed_next = '0;
            lead_next      = 1'b0;
            cr_next        = 1'b0;
            done_next      = 1'b0;
            open_next      = 1'b0;
        end
        else
        begin
            width_next     = lw;
            lbytes_next    = lb;
            consumed_next  = cons;
            committed_next = comm;
            lead_next      = lp;
            cr_next        = crp;
            done_next      = pd;
            open_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            width_reg     <= '0;
            lbytes_reg    <= '0;
            consumed_reg  <= '0;
            committed_reg <= '0;
            lead_reg      <= 1'b0;
            cr_reg        <= 1'b0;
            done_reg      <= 1'b0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cursor_reg    <= cursor_next;
                width_reg     <= width_next;
                lbytes_reg    <= lbytes_next;
                consumed_reg  <= consumed_next;
                committed_reg <= committed_next;
                lead_reg      <= lead_next;
                cr_reg        <= cr_next;
                done_reg      <= done_next;
                open_reg      <= open_next;
            end
            if (q_pop && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && res_valid)
        begin
            page_bytes_reg <= res_bytes;
            end_reason_reg <= res_reason;
        end
    end

    assign out_valid  = out_valid_reg;
    assign page_bytes = page_bytes_reg;
    assign end_reason = end_reason_reg;

endmodule

// ----- sv/text_page_break_finder.sv -----
// Top level of the text page break finder: configuration registers and the
// front, queue and back parts. Depends on tpbf_pkg, tpbf_front, tpbf_queue, tpbf_back.
//
// The block takes one GBK or ASCII text byte per cycle while in_stall is low and,
// for each text chunk ended by end_of_text, reports once how many bytes from the
// chunk start fit on one page under greedy line wrapping, along with why the page
// ended. It sustains one byte per clock unless the queue fills: the front
// classifies each byte as it is accepted, a four-entry queue holds classified
// bytes, and the back updates the layout state for one byte per cycle in a single
// step while no result is held stalled. The result is registered in the output
// register; while it waits there, up to four more bytes are still accepted into
// the queue. Bytes after the page is decided are consumed without effect until end
// of text. The configuration registers are written through a port that is always
// ready and take effect on the next byte; top_y applies from the next chunk on.
module text_page_break_finder #(
    parameter int LINE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] page_bytes,
    output logic [1:0]  end_reason,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import tpbf_pkg::*;

    logic [6:0] glyph_size_reg;
    logic [9:0] width_limit_reg;
    logic [9:0] bottom_limit_reg;
    logic [9:0] top_y_reg;
    cfg_t       cfg;
    q_status_t  q_stat;
    item_t      push_item;
    item_t      head_item;
    logic       q_push;
    logic       q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_size_reg   <= GLYPH_SIZE_RESET;
            width_limit_reg  <= WIDTH_LIMIT_RESET;
            bottom_limit_reg <= BOTTOM_LIMIT_RESET;
            top_y_reg        <= TOP_Y_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_GLYPH_SIZE:   glyph_size_reg   <= cfg_data[6:0];
                REG_WIDTH_LIMIT:  width_limit_reg  <= cfg_data;
                REG_BOTTOM_LIMIT: bottom_limit_reg <= cfg_data;
                REG_TOP_Y:        top_y_reg        <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg.glyph_size   = glyph_size_reg;
    assign cfg.width_limit  = width_limit_reg;
    assign cfg.bottom_limit = bottom_limit_reg;
    assign cfg.top_y        = top_y_reg;

    tpbf_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    tpbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    tpbf_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_stat     (q_stat),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .page_bytes (page_bytes),
        .end_reason (end_reason)
    );

endmodule

// ----- sv/tpbf_checker.sv -----
// Port-level checks of the text page break finder, bound to its top level.
// Depends on tpbf_pkg for the end reason codes.
module tpbf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] page_bytes,
    input logic [1:0]  end_reason
);
    import tpbf_pkg::*;

    // A stalled result request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(page_bytes) && $stable(end_reason))
    else $error("result changed while stalled");

    // Only the three defined end reasons are ever reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (end_reason == REASON_FULL || end_reason == REASON_END ||
                       end_reason == REASON_WIDE))
    else $error("undefined end reason");

    // The queue can only fill up while a result sat stalled in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output back-pressure");

endmodule

bind text_page_break_finder tpbf_checker u_tpbf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .page_bytes (page_bytes),
    .end_reason (end_reason)
);
